FILE: src/pft_pkg.sv
package pft_pkg;

    // Default fraction bits of the sine and cosine values
    localparam int TRIG_BITS_DEF = 16;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_POSE_X       = 2'd0;
    localparam logic [1:0] REG_POSE_Y       = 2'd1;
    localparam logic [1:0] REG_POSE_HEADING = 2'd2;
    localparam logic [1:0] REG_DIR_MODE     = 2'd3;

    // Direction modes
    localparam logic MODE_WORLD_TO_VEH = 1'b0;
    localparam logic MODE_VEH_TO_WORLD = 1'b1;

    // Q30 constants for the series evaluation
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    // Heading remainder at the octant boundary (pi/4)
    localparam logic [13:0] OCT_HALF = 14'd8192;

    // Series steps: sine uses steps 0..3, cosine steps 4..8
    localparam logic [3:0] STEP_SIN_LAST = 4'd3;
    localparam logic [3:0] STEP_COS_LAST = 4'd8;

    // Saturation limits
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               mode;
    } pose_t;

    // Horner divisor of each series step as a reciprocal and a shift:
    // floor(n / d) = (n * M) >> S for every n below 2^30
    // (divisors 72, 42, 20, 6 for sine, 90, 56, 30, 12, 2 for cosine)
    function automatic logic [30:0] trig_recip(input logic [3:0] step);
        logic [30:0] m;
        case (step)
            4'd0:    m = 31'd1908874354;
            4'd1:    m = 31'd1636178018;
            4'd2:    m = 31'd1717986919;
            4'd3:    m = 31'd1431655766;
            4'd4:    m = 31'd1527099484;
            4'd5:    m = 31'd1227133514;
            4'd6:    m = 31'd1145324613;
            4'd7:    m = 31'd1431655766;
            4'd8:    m = 31'd1073741824;
            default: m = 31'd1073741824;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] trig_shift(input logic [3:0] step);
        logic [5:0] s;
        case (step)
            4'd0:    s = 6'd37;
            4'd1:    s = 6'd36;
            4'd2:    s = 6'd35;
            4'd3:    s = 6'd33;
            4'd4:    s = 6'd37;
            4'd5:    s = 6'd36;
            4'd6:    s = 6'd35;
            4'd7:    s = 6'd34;
            4'd8:    s = 6'd31;
            default: s = 6'd31;
        endcase
        return s;
    endfunction

endpackage

FILE: src/pft_trig.sv
module pft_trig #(
    parameter int TRIG_BITS = pft_pkg::TRIG_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [15:0]               heading,
    output logic                      busy,
    output logic signed [TRIG_BITS+1:0] sin_val,
    output logic signed [TRIG_BITS+1:0] cos_val
);

    localparam int SC_W = TRIG_BITS + 2;
    localparam int RS   = 30 - TRIG_BITS;
    localparam logic [30:0] RHALF = 31'd1 << (RS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PX   = 4'd1;
    localparam logic [3:0] ST_SQ   = 4'd2;
    localparam logic [3:0] ST_X2   = 4'd3;
    localparam logic [3:0] ST_MT   = 4'd4;
    localparam logic [3:0] ST_DV0  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_MS   = 4'd7;
    localparam logic [3:0] ST_SS   = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  quad_reg, quad_next;
    logic        swap_reg, swap_next;
    logic [13:0] a_reg, a_next;
    logic [63:0] prod_reg, prod_next;
    logic [29:0] x_reg, x_next;
    logic [29:0] x2_reg, x2_next;
    logic [30:0] t_reg, t_next;
    logic [29:0] s_reg, s_next;
    logic [3:0]  step_reg, step_next;
    logic signed [SC_W-1:0] sin_reg, sin_next;
    logic signed [SC_W-1:0] cos_reg, cos_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [30:0] div_m;
    logic [5:0]  div_sh;
    logic [29:0] div_q;
    logic [13:0] r_in;
    logic        swap_in;
    logic [30:0] sb_raw, cb_raw, sb_sum, cb_sum;
    logic signed [SC_W-1:0] sbs, cbs;

    // Shared multiplier operands by sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PX: begin
                mul_a = {18'd0, a_reg};
                mul_b = pft_pkg::PI_Q30;
            end
            ST_SQ: begin
                mul_a = {2'b00, prod_reg[44:15]};
                mul_b = {2'b00, prod_reg[44:15]};
            end
            ST_MT: begin
                mul_a = {2'b00, x2_reg};
                mul_b = {1'b0, t_reg};
            end
            ST_DV0: begin
                mul_a = {2'b00, prod_reg[59:30]};
                mul_b = {1'b0, div_m};
            end
            ST_MS: begin
                mul_a = {2'b00, x_reg};
                mul_b = {1'b0, t_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Divide by the step's constant through its reciprocal
    assign div_m  = pft_pkg::trig_recip(step_reg);
    assign div_sh = pft_pkg::trig_shift(step_reg);
    assign div_q  = 30'(prod_reg >> div_sh);

    assign r_in    = heading[13:0];
    assign swap_in = (r_in > pft_pkg::OCT_HALF);

    // Swap past pi/4 and round both octant values to TRIG_BITS; ST_FIN applies the quadrant
    assign sb_raw = swap_reg ? t_reg : {1'b0, s_reg};
    assign cb_raw = swap_reg ? {1'b0, s_reg} : t_reg;
    assign sb_sum = sb_raw + RHALF;
    assign cb_sum = cb_raw + RHALF;
    assign sbs    = $signed({1'b0, sb_sum[30:RS]});
    assign cbs    = $signed({1'b0, cb_sum[30:RS]});

    always_comb begin
        state_next = state_reg;
        quad_next  = quad_reg;
        swap_next  = swap_reg;
        a_next     = a_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        t_next     = t_reg;
        s_next     = s_reg;
        step_next  = step_reg;
        sin_next   = sin_reg;
        cos_next   = cos_reg;
        if (start) begin
            quad_next  = heading[15:14];
            swap_next  = swap_in;
            a_next     = swap_in ? 14'(15'd16384 - {1'b0, r_in}) : r_in;
            state_next = ST_PX;
        end else begin
            case (state_reg)
                ST_IDLE: state_next = ST_IDLE;
                ST_PX: begin
                    prod_next  = mul_p;
                    state_next = ST_SQ;
                end
                ST_SQ: begin
                    x_next     = prod_reg[44:15];
                    prod_next  = mul_p;
                    state_next = ST_X2;
                end
                ST_X2: begin
                    x2_next    = prod_reg[59:30];
                    t_next     = pft_pkg::Q30_ONE;
                    step_next  = '0;
                    state_next = ST_MT;
                end
                ST_MT: begin
                    prod_next  = mul_p;
                    state_next = ST_DV0;
                end
                ST_DV0: begin
                    prod_next  = mul_p;
                    state_next = ST_DIV;
                end
                ST_DIV: begin
                    t_next    = pft_pkg::Q30_ONE - {1'b0, div_q};
                    step_next = step_reg + 4'd1;
                    if (step_reg == pft_pkg::STEP_SIN_LAST) begin
                        state_next = ST_MS;
                    end else if (step_reg == pft_pkg::STEP_COS_LAST) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_MT;
                    end
                end
                ST_MS: begin
                    prod_next  = mul_p;
                    state_next = ST_SS;
                end
                ST_SS: begin
                    s_next     = prod_reg[59:30];
                    t_next     = pft_pkg::Q30_ONE;
                    state_next = ST_MT;
                end
                ST_FIN: begin
                    case (quad_reg)
                        2'd0: begin
                            sin_next = sbs;
                            cos_next = cbs;
                        end
                        2'd1: begin
                            sin_next = cbs;
                            cos_next = -sbs;
                        end
                        2'd2: begin
                            sin_next = -sbs;
                            cos_next = -cbs;
                        end
                        default: begin
                            sin_next = -cbs;
                            cos_next = sbs;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sin_reg   <= '0;
            cos_reg   <= {2'b01, {TRIG_BITS{1'b0}}};
        end else begin
            state_reg <= state_next;
            sin_reg   <= sin_next;
            cos_reg   <= cos_next;
        end
    end

    always_ff @(posedge aclk) begin
        quad_reg <= quad_next;
        swap_reg <= swap_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        t_reg    <= t_next;
        s_reg    <= s_next;
        step_reg <= step_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: src/pft_rotate.sv
module pft_rotate #(
    parameter int TRIG_BITS = pft_pkg::TRIG_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pft_pkg::pose_t              pose,
    input  logic signed [TRIG_BITS+1:0] sin_val,
    input  logic signed [TRIG_BITS+1:0] cos_val,
    input  logic                        hold,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    localparam int SC_W  = TRIG_BITS + 2;
    localparam int OP_W  = 33;
    localparam int PR_W  = OP_W + SC_W;
    localparam int SUM_W = PR_W + 1;
    localparam int SH_W  = SUM_W - TRIG_BITS;
    localparam int FIN_W = SH_W + 1;
    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W - TRIG_BITS){1'b0}}, 1'b1, {(TRIG_BITS - 1){1'b0}}};

    logic a_vld_reg, a_vld_next, b_vld_reg, b_vld_next;
    logic c_vld_reg, c_vld_next, m_vld_reg, m_vld_next;
    logic a_ready, b_ready, c_ready, m_ready, in_take;

    logic signed [OP_W-1:0]  u_reg, v_reg, u_next, v_next;
    logic                    a_last_reg, b_last_reg, c_last_reg;
    logic signed [PR_W-1:0]  p_cu_reg, p_su_reg, p_cv_reg, p_sv_reg;
    logic signed [SH_W-1:0]  ex_reg, ey_reg;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [FIN_W-1:0] fx, fy;
    logic                    ovr_x, und_x, ovr_y, und_y;
    logic [31:0]             rx_reg, ry_reg, rx_next, ry_next;
    logic                    last_reg, sat_reg;
    logic signed [OP_W-1:0]  px, py, ox, oy;

    // Advance every stage that is empty or whose successor moves
    assign m_ready  = !m_vld_reg || m_tready;
    assign c_ready  = !c_vld_reg || m_ready;
    assign b_ready  = !b_vld_reg || c_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign s_tready = a_ready && !hold;
    assign in_take  = s_tvalid && s_tready;

    assign a_vld_next = a_ready ? in_take   : a_vld_reg;
    assign b_vld_next = b_ready ? a_vld_reg : b_vld_reg;
    assign c_vld_next = c_ready ? b_vld_reg : c_vld_reg;
    assign m_vld_next = m_ready ? c_vld_reg : m_vld_reg;

    // Operand stage: subtract the origin in world-to-vehicle mode
    assign px = OP_W'($signed(s_tdata[31:0]));
    assign py = OP_W'($signed(s_tdata[63:32]));
    assign ox = OP_W'(pose.x);
    assign oy = OP_W'(pose.y);
    assign u_next = (pose.mode == pft_pkg::MODE_WORLD_TO_VEH) ? px - ox : px;
    assign v_next = (pose.mode == pft_pkg::MODE_WORLD_TO_VEH) ? py - oy : py;

    // Rotation sums with the rounding half folded in
    always_comb begin
        if (pose.mode == pft_pkg::MODE_WORLD_TO_VEH) begin
            sum_x = SUM_W'(p_cu_reg) + SUM_W'(p_sv_reg) + HALF;
            sum_y = SUM_W'(p_cv_reg) - SUM_W'(p_su_reg) + HALF;
        end else begin
            sum_x = SUM_W'(p_cu_reg) - SUM_W'(p_sv_reg) + HALF;
            sum_y = SUM_W'(p_su_reg) + SUM_W'(p_cv_reg) + HALF;
        end
    end

    // Output stage: add the origin in vehicle-to-world mode, then clip
    always_comb begin
        if (pose.mode == pft_pkg::MODE_VEH_TO_WORLD) begin
            fx = FIN_W'(ex_reg) + FIN_W'(pose.x);
            fy = FIN_W'(ey_reg) + FIN_W'(pose.y);
        end else begin
            fx = FIN_W'(ex_reg);
            fy = FIN_W'(ey_reg);
        end
        ovr_x = !fx[FIN_W-1] && (fx[FIN_W-2:31] != '0);
        und_x =  fx[FIN_W-1] && (fx[FIN_W-2:31] != '1);
        ovr_y = !fy[FIN_W-1] && (fy[FIN_W-2:31] != '0);
        und_y =  fy[FIN_W-1] && (fy[FIN_W-2:31] != '1);
        rx_next = ovr_x ? pft_pkg::SAT_MAX : (und_x ? pft_pkg::SAT_MIN : fx[31:0]);
        ry_next = ovr_y ? pft_pkg::SAT_MAX : (und_y ? pft_pkg::SAT_MIN : fy[31:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            u_reg      <= u_next;
            v_reg      <= v_next;
            a_last_reg <= s_tlast;
        end
        if (b_ready && a_vld_reg) begin
            p_cu_reg   <= PR_W'(u_reg) * PR_W'(cos_val);
            p_su_reg   <= PR_W'(u_reg) * PR_W'(sin_val);
            p_cv_reg   <= PR_W'(v_reg) * PR_W'(cos_val);
            p_sv_reg   <= PR_W'(v_reg) * PR_W'(sin_val);
            b_last_reg <= a_last_reg;
        end
        if (c_ready && b_vld_reg) begin
            ex_reg     <= sum_x[SUM_W-1:TRIG_BITS];
            ey_reg     <= sum_y[SUM_W-1:TRIG_BITS];
            c_last_reg <= b_last_reg;
        end
        if (m_ready && c_vld_reg) begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            last_reg <= c_last_reg;
            sat_reg  <= ovr_x || und_x || ovr_y || und_y;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {ry_reg, rx_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = sat_reg;

endmodule

FILE: src/planar_frame_transform.sv
// Channel   Dir  Handshake         Payload
// s_        in   s_tvalid/tready   s_tdata: point_x, point_y; s_tlast: last_point
// m_        out  m_tvalid/tready   m_tdata: result_x, result_y; m_tlast: result_last;
//                                  m_tuser: saturated
// cfg_      in   cfg_wr_en         cfg_addr: register index; cfg_wr_data: value
//
// One point per cycle unless the output stalls or a heading is evaluated; each point
// passes the operand, product, sum and output registers. A heading write starts the
// sine/cosine sequencer (one shared 32x32 multiplier, series divisions done as reciprocal
// multiplications); s_tready stays low while it runs.
// Reset (aresetn low, synchronous) empties the pipeline and loads heading 0.
// A stalled result holds in the output register while the earlier stages fill.
module planar_frame_transform #(
    parameter int TRIG_BITS = pft_pkg::TRIG_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data,
    // input points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] point_x, [63:32] point_y
    input  logic        s_tlast,
    // transformed points
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] result_x, [63:32] result_y
    output logic        m_tlast,
    output logic        m_tuser    // [0] saturated
);

    localparam int SC_W = TRIG_BITS + 2;
    localparam logic signed [SC_W-1:0] TRIG_ONE = {2'b01, {TRIG_BITS{1'b0}}};

    logic signed [31:0]     pose_x_reg, pose_y_reg;
    logic                   mode_reg;
    pft_pkg::pose_t         pose;
    logic                   heading_wr;
    logic                   trig_busy;
    logic signed [SC_W-1:0] trig_sin, trig_cos;

    // Pose registers; the heading itself lives in the trig sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            mode_reg   <= pft_pkg::MODE_WORLD_TO_VEH;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pft_pkg::REG_POSE_X: pose_x_reg <= cfg_wr_data;
                pft_pkg::REG_POSE_Y: pose_y_reg <= cfg_wr_data;
                pft_pkg::REG_DIR_MODE: mode_reg <= cfg_wr_data[0];
                default: mode_reg <= mode_reg;
            endcase
        end
    end

    assign heading_wr = cfg_wr_en && (cfg_addr == pft_pkg::REG_POSE_HEADING);
    assign pose.x     = pose_x_reg;
    assign pose.y     = pose_y_reg;
    assign pose.mode  = mode_reg;

    // Recompute sine and cosine on every heading write
    pft_trig #(
        .TRIG_BITS(TRIG_BITS)
    ) u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (heading_wr),
        .heading (cfg_wr_data[15:0]),
        .busy    (trig_busy),
        .sin_val (trig_sin),
        .cos_val (trig_cos)
    );

    // Point pipeline: operands, products, rounded sums, clipped result
    pft_rotate #(
        .TRIG_BITS(TRIG_BITS)
    ) u_rotate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pose     (pose),
        .sin_val  (trig_sin),
        .cos_val  (trig_cos),
        .hold     (trig_busy),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Hold off input requests while the new heading is evaluated
    a_heading_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        heading_wr |=> !s_tready)
        else $error("input accepted right after a heading write");

    // A saturated result has at least one coordinate at a limit
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[31:0] == pft_pkg::SAT_MAX || m_tdata[31:0] == pft_pkg::SAT_MIN ||
             m_tdata[63:32] == pft_pkg::SAT_MAX || m_tdata[63:32] == pft_pkg::SAT_MIN))
        else $error("saturated flag without a clipped coordinate");

    // Sine and cosine never exceed one in magnitude
    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (trig_sin <= TRIG_ONE) && (trig_sin >= -TRIG_ONE) &&
        (trig_cos <= TRIG_ONE) && (trig_cos >= -TRIG_ONE))
        else $error("sine or cosine out of range");

    // Drop every pending result on reset
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

FILE: sim/tb_planar_frame_transform.sv
`timescale 1ns / 1ps

module tb_planar_frame_transform;

    // Fraction bits of sine/cosine; the block is built with its default
    localparam int TRIG_FRAC = pft_pkg::TRIG_BITS_DEF;
    // Cycles without any request or register write before the run is declared hung.
    // The slowest quiet stretch is the long receiver hold-off or the
    // sine/cosine sequencer run after a heading write.
    localparam int HANG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        logic               sat;
    } point_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;      // [31:0] point_x, [63:32] point_y
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [31:0] result_x, [63:32] result_y
    logic        m_tlast;
    logic        m_tuser;           // [0] saturated

    // Shadow copy of the pose registers, updated as each write lands
    logic signed [31:0] cfg_pose_x = '0;
    logic signed [31:0] cfg_pose_y = '0;
    logic [15:0]        cfg_heading = '0;
    logic               cfg_mode = pft_pkg::MODE_WORLD_TO_VEH;

    // Transformed points still owed by the block, oldest first
    point_result_t pending_points[$];

    int  mismatches = 0;
    int  points_sent = 0;
    int  results_seen = 0;
    int  sat_seen = 0;
    int  pose_settings = 0;
    int  hold_cycles = 0;       // receiver hold-off request, counted down by the receiver
    bit  tx_gaps = 1'b1;        // sender inserts idle bursts
    bit  rx_gaps = 1'b1;        // receiver inserts stall bursts

    planar_frame_transform #(
        .TRIG_BITS (TRIG_FRAC)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // floor((v + 2^(n-1)) / 2^n): round half toward plus infinity
    function automatic longint round_half_up(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v, inout logic sat);
        if (v > longint'(COORD_MAX)) begin
            sat = 1'b1;
            return COORD_MAX;
        end
        if (v < longint'(COORD_MIN)) begin
            sat = 1'b1;
            return COORD_MIN;
        end
        return v[31:0];
    endfunction

    // Sine and cosine of a binary angle, TRIG_FRAC fraction bits.
    // Evaluate the series on the first octant only; above pi/4 within a quadrant
    // take the complement angle and swap sine and cosine.
    function automatic void heading_sin_cos(input logic [15:0] h, output longint sn,
                                            output longint cs);
        logic [13:0] r;
        longint      a, x, x2, t, one, s_q30, c_q30, sb, cb;
        r   = h[13:0];
        one = longint'(pft_pkg::Q30_ONE);
        a = (r > pft_pkg::OCT_HALF) ? 64'sd16384 - longint'(r) : longint'(r);
        x  = (a * longint'(pft_pkg::PI_Q30)) >>> 15;
        x2 = (x * x) >>> 30;
        // sine through x^9
        t = one - x2 / 72;
        t = one - ((x2 * t) >>> 30) / 42;
        t = one - ((x2 * t) >>> 30) / 20;
        t = one - ((x2 * t) >>> 30) / 6;
        s_q30 = (x * t) >>> 30;
        // cosine through x^10
        t = one - x2 / 90;
        t = one - ((x2 * t) >>> 30) / 56;
        t = one - ((x2 * t) >>> 30) / 30;
        t = one - ((x2 * t) >>> 30) / 12;
        c_q30 = one - ((x2 * t) >>> 30) / 2;
        if (r > pft_pkg::OCT_HALF) begin
            sb = c_q30;
            cb = s_q30;
        end else begin
            sb = s_q30;
            cb = c_q30;
        end
        sb = round_half_up(sb, 30 - TRIG_FRAC);
        cb = round_half_up(cb, 30 - TRIG_FRAC);
        // quadrant sets the signs
        case (h[15:14])
            2'd0: begin sn = sb;  cs = cb;  end
            2'd1: begin sn = cb;  cs = -sb; end
            2'd2: begin sn = -sb; cs = -cb; end
            default: begin sn = -cb; cs = sb; end
        endcase
    endfunction

    function automatic point_result_t transform_point(input logic signed [31:0] px,
                                                      input logic signed [31:0] py,
                                                      input logic last);
        point_result_t res;
        longint        sn, cs, ax, ay, rx, ry;
        heading_sin_cos(cfg_heading, sn, cs);
        if (cfg_mode == pft_pkg::MODE_WORLD_TO_VEH) begin
            // keep the full-width difference, rotate by minus the heading
            ax = longint'(px) - longint'(cfg_pose_x);
            ay = longint'(py) - longint'(cfg_pose_y);
            sn = -sn;
            rx = round_half_up(cs * ax - sn * ay, TRIG_FRAC);
            ry = round_half_up(sn * ax + cs * ay, TRIG_FRAC);
        end else begin
            ax = longint'(px);
            ay = longint'(py);
            rx = round_half_up(cs * ax - sn * ay, TRIG_FRAC) + longint'(cfg_pose_x);
            ry = round_half_up(sn * ax + cs * ay, TRIG_FRAC) + longint'(cfg_pose_y);
        end
        res.sat  = 1'b0;
        res.x    = clip32(rx, res.sat);
        res.y    = clip32(ry, res.sat);
        res.last = last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    // Mostly moderate magnitudes so the rotation is exercised without clipping,
    // with a share of full-range values and the corners of the range.
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = COORD_MAX;
                    1: v = COORD_MIN;
                    2: v = '0;
                    3: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            1, 2: v = $urandom;
            default: v = $signed($urandom) >>> $urandom_range(5, 23);
        endcase
        return v;
    endfunction

    // Any angle, with the quadrant and octant boundaries favored
    function automatic logic [15:0] rand_heading();
        logic [15:0] h;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 7))
                0: h = 16'h0000;
                1: h = 16'h2000;
                2: h = 16'h2001;
                3: h = 16'h4000;
                4: h = 16'h7FFF;
                5: h = 16'h8000;
                6: h = 16'hC000;
                default: h = 16'hFFFF;
            endcase
        end else begin
            h = 16'($urandom_range(0, 16'hFFFF));
        end
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Write one register and mirror it in the shadow pose
    task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (addr)
            pft_pkg::REG_POSE_X:       cfg_pose_x  = data;
            pft_pkg::REG_POSE_Y:       cfg_pose_y  = data;
            pft_pkg::REG_POSE_HEADING: cfg_heading = data[15:0];
            pft_pkg::REG_DIR_MODE:     cfg_mode    = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Load a full pose; write the heading last since it restarts the
    // sine/cosine sequencer and holds off input requests
    task automatic set_pose(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic [15:0] heading, input logic mode);
        write_reg(pft_pkg::REG_POSE_X, x);
        write_reg(pft_pkg::REG_POSE_Y, y);
        write_reg(pft_pkg::REG_DIR_MODE, {31'b0, mode});
        write_reg(pft_pkg::REG_POSE_HEADING, {{16{heading[15]}}, heading});
        pose_settings++;
    endtask

    // Offer one point and hold it until the block takes the request
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic last);
        int gap;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pending_points.push_back(transform_point(x, y, last));
        points_sent++;
    endtask

    // Drop valid and wait for every owed result, so registers may be rewritten
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_points(input int count);
        repeat (count) send_point(rand_coord(), rand_coord(), ($urandom_range(0, 7) == 0));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each result request with the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_result();
        point_result_t got, want;
        got.x    = m_tdata[31:0];
        got.y    = m_tdata[63:32];
        got.last = m_tlast;
        got.sat  = m_tuser;
        results_seen++;
        if (got.sat === 1'b1) sat_seen++;
        if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] unexpected result x=%0d y=%0d last=%b sat=%b",
                         $realtime, got.x, got.y, got.last, got.sat);
            return;
        end
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
            got.sat !== want.sat) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"[%0t] result %0d: expected x=%0d y=%0d last=%b sat=%b,",
                          " got x=%0d y=%0d last=%b sat=%b"},
                         $realtime, results_seen, want.x, want.y, want.last, want.sat,
                         got.x, got.y, got.last, got.sat);
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) check_result();
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no request and no register write
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no progress for %0d cycles, %0d results owed",
                 $realtime, HANG_LIMIT, pending_points.size());
        $display("planar_frame_transform verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset pose is the identity: every point must come back unchanged
    task automatic test_reset_identity();
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b1);
        send_point(-32'sd1, 32'sd1, 1'b0);
        drain();
    endtask

    // Extreme origin with a quarter turn: the full-width difference must not
    // wrap before the rotation, and both coordinates of the first point clip
    task automatic test_world_to_vehicle_extremes();
        set_pose(COORD_MAX, COORD_MIN, 16'h4000, pft_pkg::MODE_WORLD_TO_VEH);
        send_point(COORD_MIN, COORD_MAX, 1'b1);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b0);
        drain();
    endtask

    // At pi/4 the cosine is odd, so half-unit inputs land exactly on rounding
    // ties (both signs); just past pi/4 sine and cosine swap roles
    task automatic test_octant_and_ties();
        set_pose(32'sd0, 32'sd0, 16'h2000, pft_pkg::MODE_VEH_TO_WORLD);
        send_point(32'sh0000_8000, 32'sd0, 1'b0);
        send_point(-32'sh0000_8000, 32'sd0, 1'b0);
        send_point(32'sd0, 32'sh0000_8000, 1'b1);
        drain();
        write_reg(pft_pkg::REG_POSE_HEADING, 32'h0000_2001);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(32'sh0001_0000, -32'sh0003_0000, 1'b1);
        drain();
    endtask

    // Half turn with extreme origin, then the wrap points of the angle
    task automatic test_heading_extremes();
        set_pose(COORD_MIN, COORD_MAX, 16'h8000, pft_pkg::MODE_VEH_TO_WORLD);
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        drain();
        set_pose(-32'sd1, 32'sd1, 16'h7FFF, pft_pkg::MODE_WORLD_TO_VEH);
        send_point(32'sd1, -32'sd1, 1'b0);
        send_point(32'sh0123_4567, -32'sh0765_4321, 1'b1);
        drain();
        write_reg(pft_pkg::REG_POSE_HEADING, 32'hFFFF_FFFF);
        send_point(32'sh0010_0000, 32'sh0020_0000, 1'b0);
        drain();
        write_reg(pft_pkg::REG_POSE_HEADING, 32'hFFFF_C000);
        send_point(32'sh0010_0000, 32'sh0020_0000, 1'b1);
        drain();
    endtask

    // Random poses in both directions, a batch of random points under each
    task automatic test_random_poses(input int batches, input int per_batch);
        repeat (batches) begin
            set_pose(rand_coord(), rand_coord(), rand_heading(), $urandom_range(0, 1));
            send_random_points(per_batch);
            drain();
        end
    endtask

    // Hold the receiver off while points keep coming, so the pipeline fills
    // and the input side must stall
    task automatic test_output_backpressure();
        set_pose(rand_coord(), rand_coord(), rand_heading(), $urandom_range(0, 1));
        hold_cycles = 300;
        tx_gaps = 1'b0;
        send_random_points(40);
        tx_gaps = 1'b1;
        drain();
    endtask

    // Back-to-back traffic on both sides, no idling anywhere
    task automatic test_full_rate();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (3) begin
            set_pose(rand_coord(), rand_coord(), rand_heading(), $urandom_range(0, 1));
            send_random_points(50);
            drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_identity();
        test_world_to_vehicle_extremes();
        test_octant_and_ties();
        test_heading_extremes();
        test_random_poses(11, 100);
        test_output_backpressure();
        test_full_rate();

        // let any stray result surface before the verdict
        repeat (20) @(posedge aclk);
        if (pending_points.size() != 0) mismatches++;

        $display("Sent %0d points under %0d poses in both directions,",
                 points_sent, pose_settings);
        $display("  octant, tie and wrap angles; %0d results (%0d clipped), %0d mismatches.",
                 results_seen, sat_seen, mismatches);
        if (mismatches == 0)
            $display("planar_frame_transform verification clean");
        else
            $display("planar_frame_transform verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/pft_pkg.sv
src/pft_trig.sv
src/pft_rotate.sv
src/planar_frame_transform.sv
sim/tb_planar_frame_transform.sv
